// ===== design/nmea_rmc_time_extractor_core_defines.svh =====
// ----------------------------------------------------------------------------
// NMEA RMC time extractor: assertion macros
// Concurrent check shorthands shared by the files that assert.
// ----------------------------------------------------------------------------
`ifndef NMEA_RMC_TIME_EXTRACTOR_CORE_DEFINES_SVH
`define NMEA_RMC_TIME_EXTRACTOR_CORE_DEFINES_SVH

// Same-cycle implication, off during reset
`define NRTE_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nrte: same-cycle check failed");

// Next-cycle implication, off during reset
`define NRTE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nrte: next-cycle check failed");

`endif

// ===== design/nrte_pkg.sv =====
// ----------------------------------------------------------------------------
// NMEA RMC time extractor: shared package
// Types, constants and lookup functions used by the parser front, the line
// queue and the conversion back end.
// ----------------------------------------------------------------------------
package nrte_pkg;

  // Line queue sizing
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Sentence framing
  localparam logic [2:0] PREFIX_LEN      = 3'd6;
  localparam logic [2:0] BYTE_CNT_SAT    = 3'd7;
  localparam logic [3:0] FIELD_CNT_SAT   = 4'd15;
  localparam logic [3:0] COMMAS_REQUIRED = 4'd12;
  localparam logic [3:0] TIME_FIELD_IDX  = 4'd1;
  localparam logic [3:0] DATE_FIELD_IDX  = 4'd9;
  localparam logic [3:0] TIME_FIELD_LEN  = 4'd9;
  localparam logic [3:0] DATE_FIELD_LEN  = 4'd6;
  localparam logic [3:0] DIGIT_FIELD_LEN = 4'd6;
  localparam logic [3:0] FRAC_POS_LO     = 4'd7;
  localparam logic [3:0] FRAC_POS_HI     = 4'd8;

  // Character codes
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Calendar and time constants
  localparam logic [15:0] DAYS_1970_TO_2000 = 16'd10957;
  localparam logic [31:0] SECS_PER_DAY      = 32'd86400;
  localparam logic [16:0] SECS_PER_HOUR     = 17'd3600;
  localparam logic [16:0] SECS_PER_MIN      = 17'd60;
  localparam logic [19:0] USEC_PER_TENTH    = 20'd100000;
  localparam logic [19:0] USEC_PER_HUNDR    = 20'd10000;
  localparam logic [31:0] EPOCH_MAX         = 32'd4102444799;
  localparam logic [19:0] USEC_MAX          = 20'd990000;

  // One finished line as handed from the front to the back end
  typedef struct packed {
    logic            hdr_ok;  // length, prefix, comma count and field checks passed
    logic [7:0][3:0] tdig;    // hhmmss then tenths and hundredths
    logic [5:0][3:0] ddig;    // ddmmyy
  } line_rec_t;

  // Conversion sequencer
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CHECK,
    BK_MUL,
    BK_SUM
  } back_state_t;

  // Expected sentence header "$GPRMC"
  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h24;
      3'd1:    c = 8'h47;
      3'd2:    c = 8'h50;
      3'd3:    c = 8'h52;
      3'd4:    c = 8'h4D;
      3'd5:    c = 8'h43;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  // Days before the first of a month (month 1..12), non-leap
  function automatic logic [8:0] days_before_month(input logic [3:0] mo);
    logic [8:0] d;
    unique case (mo)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // Length of a month (month 1..12)
  function automatic logic [4:0] month_length(input logic [3:0] mo, input logic leap);
    logic [4:0] n;
    unique case (mo)
      4'd2:                         n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:      n = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7,
      4'd8, 4'd10, 4'd12:           n = 5'd31;
      default:                      n = 5'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== design/nmea_rmc_time_extractor_core.sv =====
// A line of NMEA text enters one byte per request, the last byte marked by
// in_end_of_line; that byte produces exactly one result request, other bytes
// none. The parser front takes one byte every cycle and stalls only while its
// two-entry line queue is full. The back end converts one queued line through
// queue read, range check and day count, day-to-second multiply and final
// sum, then holds the result in its output register until taken; it pops the
// next line only once that result is loaded. A result carries time_valid,
// epoch seconds for dates in 2000..2099 and microseconds from the two fraction
// digits; both numbers are zero when time_valid is low.
// ----------------------------------------------------------------------------
// NMEA RMC time extractor: top level
// Connects the parser front, the line queue and the conversion back end.
// ----------------------------------------------------------------------------
`include "nmea_rmc_time_extractor_core_defines.svh"

module nmea_rmc_time_extractor_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_line_byte,
  input  logic        in_end_of_line,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_time_valid,
  output logic [31:0] out_epoch_seconds,
  output logic [19:0] out_micro_seconds
);

  nrte_pkg::line_rec_t wr_rec;
  nrte_pkg::line_rec_t rd_rec;
  logic                q_push;
  logic                q_pop;
  logic                q_full;
  logic                q_empty;

  nrte_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_line_byte   (in_line_byte),
    .in_end_of_line (in_end_of_line),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_rec          (wr_rec)
  );

  nrte_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_rec (wr_rec),
    .pop    (q_pop),
    .rd_rec (rd_rec),
    .full   (q_full),
    .empty  (q_empty)
  );

  nrte_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_rec             (rd_rec),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_time_valid    (out_time_valid),
    .out_epoch_seconds (out_epoch_seconds),
    .out_micro_seconds (out_micro_seconds)
  );

  // Never lose a line record to a full queue
  `NRTE_ASSERT_IMPLIES(a_no_push_when_full, q_push, !q_full)
  // Never pop an empty queue
  `NRTE_ASSERT_IMPLIES(a_no_pop_when_empty, q_pop, !q_empty)
  // Invalid results carry zero time
  `NRTE_ASSERT_IMPLIES(a_invalid_zero, out_valid && !out_time_valid, out_epoch_seconds == 32'd0 && out_micro_seconds == 20'd0)
  // Valid results stay inside the supported century and fraction range
  `NRTE_ASSERT_IMPLIES(a_valid_range, out_valid && out_time_valid, out_epoch_seconds <= nrte_pkg::EPOCH_MAX && out_micro_seconds <= nrte_pkg::USEC_MAX)

endmodule

// ===== design/nrte_fifo.sv =====
// ----------------------------------------------------------------------------
// NMEA RMC time extractor: line queue
// Short first-in first-out store of finished line records between the
// parser front and the conversion back end.
// ----------------------------------------------------------------------------
module nrte_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  nrte_pkg::line_rec_t wr_rec,
  input  logic               pop,
  output nrte_pkg::line_rec_t rd_rec,
  output logic               full,
  output logic               empty
);

  nrte_pkg::line_rec_t               mem [nrte_pkg::QUEUE_DEPTH];
  logic [nrte_pkg::QPTR_W-1:0]       wr_ptr_r;
  logic [nrte_pkg::QPTR_W-1:0]       rd_ptr_r;
  logic [nrte_pkg::QCNT_W-1:0]       count_r;
  logic                              do_push;
  logic                              do_pop;

  localparam logic [nrte_pkg::QPTR_W-1:0] PTR_LAST = nrte_pkg::QPTR_W'(nrte_pkg::QUEUE_DEPTH - 1);
  localparam logic [nrte_pkg::QCNT_W-1:0] CNT_FULL = nrte_pkg::QCNT_W'(nrte_pkg::QUEUE_DEPTH);

  assign full    = (count_r == CNT_FULL);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_rec  = mem[rd_ptr_r];

  // Store an incoming record
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_rec;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== design/nrte_front.sv =====
// ----------------------------------------------------------------------------
// NMEA RMC time extractor: parser front
// Takes one line byte per cycle unless the line queue is full; tracks header,
// commas, field lengths, time and date digits and queues a record at line end.
// ----------------------------------------------------------------------------
module nrte_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_line_byte,
  input  logic                in_end_of_line,
  input  logic                q_full,
  output logic                q_push,
  output nrte_pkg::line_rec_t q_rec
);

  logic [2:0]      byte_cnt_r, byte_cnt_nxt;
  logic            mism_r, mism_nxt;
  logic [3:0]      comma_cnt_r, comma_cnt_nxt;
  logic [3:0]      chars_r, chars_nxt;
  logic            ferr_r, ferr_nxt;
  logic [7:0][3:0] tdig_r, tdig_nxt;
  logic [5:0][3:0] ddig_r, ddig_nxt;
  logic            acc;
  logic            byte_is_digit;
  logic [2:0]      frac_slot;

  // Hold off requests while the line queue is full
  assign in_stall      = q_full;
  assign acc           = in_valid && !q_full;
  assign q_push        = acc && in_end_of_line;
  assign byte_is_digit = nrte_pkg::is_digit(in_line_byte);
  assign frac_slot     = chars_r[2:0] - 3'd1;

  // Update the line state for the current byte
  always_comb begin
    byte_cnt_nxt  = byte_cnt_r;
    mism_nxt      = mism_r;
    comma_cnt_nxt = comma_cnt_r;
    chars_nxt     = chars_r;
    ferr_nxt      = ferr_r;
    tdig_nxt      = tdig_r;
    ddig_nxt      = ddig_r;

    if (byte_cnt_r < nrte_pkg::PREFIX_LEN &&
        in_line_byte != nrte_pkg::prefix_char(byte_cnt_r)) begin
      mism_nxt = 1'b1;
    end
    if (byte_cnt_r < nrte_pkg::BYTE_CNT_SAT) begin
      byte_cnt_nxt = byte_cnt_r + 3'd1;
    end

    if (in_line_byte == nrte_pkg::CHAR_COMMA) begin
      // Close the field and check its length
      if (comma_cnt_r == nrte_pkg::TIME_FIELD_IDX && chars_r != nrte_pkg::TIME_FIELD_LEN) begin
        ferr_nxt = 1'b1;
      end
      if (comma_cnt_r == nrte_pkg::DATE_FIELD_IDX && chars_r != nrte_pkg::DATE_FIELD_LEN) begin
        ferr_nxt = 1'b1;
      end
      if (comma_cnt_r < nrte_pkg::FIELD_CNT_SAT) begin
        comma_cnt_nxt = comma_cnt_r + 4'd1;
      end
      chars_nxt = '0;
    end else begin
      // Capture digits of the time and date fields
      if (comma_cnt_r == nrte_pkg::TIME_FIELD_IDX) begin
        if (chars_r < nrte_pkg::DIGIT_FIELD_LEN) begin
          if (byte_is_digit) begin
            tdig_nxt[chars_r[2:0]] = in_line_byte[3:0];
          end else begin
            ferr_nxt = 1'b1;
          end
        end else if (chars_r == nrte_pkg::FRAC_POS_LO || chars_r == nrte_pkg::FRAC_POS_HI) begin
          if (byte_is_digit) begin
            tdig_nxt[frac_slot] = in_line_byte[3:0];
          end else begin
            ferr_nxt = 1'b1;
          end
        end
      end else if (comma_cnt_r == nrte_pkg::DATE_FIELD_IDX) begin
        if (chars_r < nrte_pkg::DIGIT_FIELD_LEN) begin
          if (byte_is_digit) begin
            ddig_nxt[chars_r[2:0]] = in_line_byte[3:0];
          end else begin
            ferr_nxt = 1'b1;
          end
        end
      end
      if (chars_r < nrte_pkg::FIELD_CNT_SAT) begin
        chars_nxt = chars_r + 4'd1;
      end
    end
  end

  // Build the record for the end-marked byte
  always_comb begin
    q_rec.hdr_ok = (byte_cnt_nxt == nrte_pkg::BYTE_CNT_SAT) && !mism_nxt && !ferr_nxt &&
                   (comma_cnt_nxt == nrte_pkg::COMMAS_REQUIRED);
    q_rec.tdig   = tdig_nxt;
    q_rec.ddig   = ddig_nxt;
  end

  // Advance control state, clear it after the last byte of a line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_cnt_r  <= '0;
      mism_r      <= 1'b0;
      comma_cnt_r <= '0;
      chars_r     <= '0;
      ferr_r      <= 1'b0;
    end else if (acc) begin
      if (in_end_of_line) begin
        byte_cnt_r  <= '0;
        mism_r      <= 1'b0;
        comma_cnt_r <= '0;
        chars_r     <= '0;
        ferr_r      <= 1'b0;
      end else begin
        byte_cnt_r  <= byte_cnt_nxt;
        mism_r      <= mism_nxt;
        comma_cnt_r <= comma_cnt_nxt;
        chars_r     <= chars_nxt;
        ferr_r      <= ferr_nxt;
      end
    end
  end

  // Hold captured digits; every digit of a passing line is rewritten
  always_ff @(posedge clk) begin
    if (acc) begin
      tdig_r <= tdig_nxt;
      ddig_r <= ddig_nxt;
    end
  end

endmodule

// ===== design/nrte_back.sv =====
// ----------------------------------------------------------------------------
// NMEA RMC time extractor: conversion back end
// Pops one line record, checks value ranges, counts days since 1970 and
// forms epoch seconds and microseconds in an output register.
// ----------------------------------------------------------------------------
module nrte_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  nrte_pkg::line_rec_t q_rec,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_time_valid,
  output logic [31:0]         out_epoch_seconds,
  output logic [19:0]         out_micro_seconds
);

  nrte_pkg::back_state_t state_r, state_nxt;

  logic        ld_days;
  logic        ld_prod;
  logic        ld_out;
  logic        out_valid_r;
  logic        out_tv_r;
  logic [31:0] out_sec_r;
  logic [19:0] out_usec_r;

  logic [6:0]  hh_r, mi_r, ss_r, dd_r, mo_r, yy_r;
  logic [3:0]  tenth_r, hundr_r;
  logic        hdr_ok_r;
  logic        ok_r;
  logic [15:0] days_r;
  logic [31:0] prod_r;
  logic [16:0] hms_r;
  logic [19:0] usec_r;

  logic        leap;
  logic [4:0]  mlen;
  logic        range_ok;
  logic [7:0]  yy_quarter;
  logic [15:0] days_c;

  // Sequence one line through check, multiply and sum
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    ld_days   = 1'b0;
    ld_prod   = 1'b0;
    ld_out    = 1'b0;
    unique case (state_r)
      nrte_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = nrte_pkg::BK_CHECK;
        end
      end
      nrte_pkg::BK_CHECK: begin
        ld_days   = 1'b1;
        state_nxt = nrte_pkg::BK_MUL;
      end
      nrte_pkg::BK_MUL: begin
        ld_prod   = 1'b1;
        state_nxt = nrte_pkg::BK_SUM;
      end
      nrte_pkg::BK_SUM: begin
        if (!out_valid_r || !out_stall) begin
          ld_out    = 1'b1;
          state_nxt = nrte_pkg::BK_IDLE;
        end
      end
      default: state_nxt = nrte_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nrte_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Range checks and day count from the registered fields
  always_comb begin
    leap       = (yy_r[1:0] == 2'd0);
    mlen       = nrte_pkg::month_length(mo_r[3:0], leap);
    range_ok   = (hh_r <= 7'd23) && (mi_r <= 7'd59) && (ss_r <= 7'd59) &&
                 (mo_r >= 7'd1) && (mo_r <= 7'd12) && (dd_r >= 7'd1) &&
                 (dd_r <= {2'b00, mlen});
    yy_quarter = (8'(yy_r) + 8'd3) >> 2;
    days_c     = nrte_pkg::DAYS_1970_TO_2000 + 16'(yy_r) * 16'd365 + 16'(yy_quarter) +
                 16'(nrte_pkg::days_before_month(mo_r[3:0])) + 16'(dd_r) - 16'd1 +
                 16'((mo_r > 7'd2) && leap);
  end

  // Load decimal fields from the popped record
  always_ff @(posedge clk) begin
    if (q_pop) begin
      hh_r     <= 7'(q_rec.tdig[0]) * 7'd10 + 7'(q_rec.tdig[1]);
      mi_r     <= 7'(q_rec.tdig[2]) * 7'd10 + 7'(q_rec.tdig[3]);
      ss_r     <= 7'(q_rec.tdig[4]) * 7'd10 + 7'(q_rec.tdig[5]);
      tenth_r  <= q_rec.tdig[6];
      hundr_r  <= q_rec.tdig[7];
      dd_r     <= 7'(q_rec.ddig[0]) * 7'd10 + 7'(q_rec.ddig[1]);
      mo_r     <= 7'(q_rec.ddig[2]) * 7'd10 + 7'(q_rec.ddig[3]);
      yy_r     <= 7'(q_rec.ddig[4]) * 7'd10 + 7'(q_rec.ddig[5]);
      hdr_ok_r <= q_rec.hdr_ok;
    end
    if (ld_days) begin
      ok_r   <= hdr_ok_r && range_ok;
      days_r <= days_c;
    end
    if (ld_prod) begin
      prod_r <= 32'(days_r) * nrte_pkg::SECS_PER_DAY;
      hms_r  <= 17'(hh_r) * nrte_pkg::SECS_PER_HOUR + 17'(mi_r) * nrte_pkg::SECS_PER_MIN +
                17'(ss_r);
      usec_r <= 20'(tenth_r) * nrte_pkg::USEC_PER_TENTH +
                20'(hundr_r) * nrte_pkg::USEC_PER_HUNDR;
    end
  end

  // Output register: fill on completion, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ld_out || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      out_tv_r   <= ok_r;
      out_sec_r  <= ok_r ? prod_r + 32'(hms_r) : '0;
      out_usec_r <= ok_r ? usec_r : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_time_valid    = out_tv_r;
  assign out_epoch_seconds = out_sec_r;
  assign out_micro_seconds = out_usec_r;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// NMEA RMC time extractor: testbench
// Streams $GPRMC sentences, damaged sentences and byte noise into the core one
// byte per request, tracks every accepted byte with a parser of its own and
// checks each end-of-line result field by field. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 12;
  localparam int IDLE_PCT     = 15;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 24;
  localparam int TARGET_BYTES = 950;
  // accepted-byte window in which neither side idles
  localparam int CALM_FIRST   = 350;
  localparam int CALM_LAST    = 650;

  localparam logic [7:0]  CH_COMMA      = 8'h2C;
  localparam logic [7:0]  CH_ZERO       = 8'h30;
  localparam logic [7:0]  CH_NINE       = 8'h39;
  localparam logic [47:0] RMC_HEAD      = "$GPRMC";
  localparam logic [3:0]  COMMAS_NEEDED = 4'd12;
  localparam logic [3:0]  TIME_IDX      = 4'd1;
  localparam logic [3:0]  DATE_IDX      = 4'd9;
  localparam logic [3:0]  TIME_LEN      = 4'd9;
  localparam logic [3:0]  DATE_LEN      = 4'd6;
  localparam logic [3:0]  LEN_SAT       = 4'hF;
  localparam logic [2:0]  COUNT_SAT     = 3'd7;
  localparam int          TIME_START    = 7;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } line_byte_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] secs;
    logic [19:0] usecs;
  } rmc_time_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_line_byte = 8'h00;
  logic        in_end_of_line = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_time_valid;
  logic [31:0] out_epoch_seconds;
  logic [19:0] out_micro_seconds;

  line_byte_t  tx_bytes[$];
  rmc_time_t   pending_times[$];
  logic [7:0]  line_buf[$];
  int          errors = 0;
  int          bytes_taken = 0;
  int          quiet_cycles = 0;
  logic        calm;

  // Parser state tracked alongside the core
  logic [2:0]  p_bytes;
  logic        p_head_bad;
  logic [3:0]  p_commas;
  logic [3:0]  p_flen;
  logic [3:0]  p_tdig [8];
  logic [3:0]  p_ddig [6];
  logic        p_ferr;

  nmea_rmc_time_extractor_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_line_byte     (in_line_byte),
    .in_end_of_line   (in_end_of_line),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_time_valid   (out_time_valid),
    .out_epoch_seconds(out_epoch_seconds),
    .out_micro_seconds(out_micro_seconds)
  );

  assign calm = (bytes_taken >= CALM_FIRST) && (bytes_taken < CALM_LAST);

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic int month_days(input int mo, input bit leap);
    case (mo)
      2:            return leap ? 29 : 28;
      4, 6, 9, 11:  return 30;
      default:      return 31;
    endcase
  endfunction

  task automatic clear_parser();
    p_bytes    = '0;
    p_head_bad = 1'b0;
    p_commas   = '0;
    p_flen     = '0;
    p_ferr     = 1'b0;
    for (int i = 0; i < 8; i++) p_tdig[i] = '0;
    for (int i = 0; i < 6; i++) p_ddig[i] = '0;
  endtask

  // Advance the parser by one accepted byte
  task automatic take_rmc_byte(input logic [7:0] c);
    logic is_dig;
    int   slot;
    is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
    if (p_bytes < 3'd6 && c != RMC_HEAD[47 - 8 * int'(p_bytes) -: 8]) p_head_bad = 1'b1;
    if (p_bytes != COUNT_SAT) p_bytes++;
    if (c == CH_COMMA) begin
      if (p_commas == TIME_IDX && p_flen != TIME_LEN) p_ferr = 1'b1;
      if (p_commas == DATE_IDX && p_flen != DATE_LEN) p_ferr = 1'b1;
      if (p_commas != LEN_SAT) p_commas++;
      p_flen = '0;
    end else begin
      // hhmmss in slots 0..5, fraction digits from positions 7 and 8
      if (p_commas == TIME_IDX && (p_flen < 4'd6 || p_flen == 4'd7 || p_flen == 4'd8)) begin
        slot = (p_flen < 4'd6) ? int'(p_flen) : int'(p_flen) - 1;
        if (is_dig) p_tdig[slot] = c[3:0];
        else p_ferr = 1'b1;
      end
      if (p_commas == DATE_IDX && p_flen < 4'd6) begin
        if (is_dig) p_ddig[p_flen] = c[3:0];
        else p_ferr = 1'b1;
      end
      if (p_flen != LEN_SAT) p_flen++;
    end
  endtask

  // Turn the finished line into the expected result
  function automatic rmc_time_t convert_rmc();
    rmc_time_t r;
    int        hh, mi, ss, dd, mo, yy, days;
    bit        leap;
    r = '0;
    if (p_bytes != COUNT_SAT || p_head_bad || p_ferr || p_commas != COMMAS_NEEDED) return r;
    hh = p_tdig[0] * 10 + p_tdig[1];
    mi = p_tdig[2] * 10 + p_tdig[3];
    ss = p_tdig[4] * 10 + p_tdig[5];
    dd = p_ddig[0] * 10 + p_ddig[1];
    mo = p_ddig[2] * 10 + p_ddig[3];
    yy = p_ddig[4] * 10 + p_ddig[5];
    leap = (yy % 4 == 0);
    if (hh > 23 || mi > 59 || ss > 59 || mo < 1 || mo > 12 || dd < 1) return r;
    if (dd > month_days(mo, leap)) return r;
    days = 10957 + 365 * yy + (yy + 3) / 4 + dd - 1;
    for (int m = 1; m < mo; m++) days += month_days(m, leap);
    r.ok    = 1'b1;
    r.secs  = 32'(longint'(days) * 86400 + hh * 3600 + mi * 60 + ss);
    r.usecs = 20'(p_tdig[6] * 100000 + p_tdig[7] * 10000);
    return r;
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  // Move the line under construction into the send queue, end-marked
  task automatic flush_line();
    line_byte_t b;
    for (int i = 0; i < line_buf.size(); i++) begin
      b.data = line_buf[i];
      b.last = (i == line_buf.size() - 1);
      tx_bytes.push_back(b);
    end
    line_buf.delete();
  endtask

  // Build a sentence; rich fills the fields that carry no time
  task automatic build_rmc(input int hh, input int mi, input int ss, input int fr,
                           input int dd, input int mo, input int yy, input bit rich);
    logic [7:0] ch;
    line_buf.delete();
    add_text("$GPRMC");
    for (int f = 1; f <= 12; f++) begin
      line_buf.push_back(CH_COMMA);
      if (f == TIME_IDX) add_text($sformatf("%02d%02d%02d.%02d", hh, mi, ss, fr));
      else if (f == DATE_IDX) add_text($sformatf("%02d%02d%02d", dd, mo, yy));
      else if (rich) begin
        repeat ($urandom_range(0, 6)) begin
          ch = 8'($urandom_range(33, 126));
          line_buf.push_back((ch == CH_COMMA) ? CH_ZERO : ch);
        end
      end
    end
  endtask

  function automatic int comma_pos(input int n);
    int seen;
    seen = 0;
    for (int i = 0; i < line_buf.size(); i++) begin
      if (line_buf[i] == CH_COMMA) begin
        seen++;
        if (seen == n) return i;
      end
    end
    return 0;
  endfunction

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
      errors++;
    end
  endtask

  // Stimulus: directed sentences, then random sentences, damage and noise
  initial begin : stimulus
    int hh, mi, ss, fr, dd, mo, yy, pick, pos;

    // earliest and latest representable times
    build_rmc(0, 0, 0, 0, 1, 1, 0, 0);       flush_line();
    build_rmc(23, 59, 59, 99, 31, 12, 99, 1); add_text("A*6C"); flush_line();
    // leap day in a leap year, and in a common year
    build_rmc(12, 30, 15, 50, 29, 2, 4, 0);  flush_line();
    build_rmc(12, 30, 15, 50, 29, 2, 1, 0);  flush_line();
    // first of March after a leap February
    build_rmc(6, 7, 8, 9, 1, 3, 0, 0);       flush_line();
    // out-of-range values
    build_rmc(24, 0, 0, 0, 1, 1, 10, 0);     flush_line();
    build_rmc(0, 60, 0, 0, 1, 1, 10, 0);     flush_line();
    build_rmc(0, 0, 60, 0, 1, 1, 10, 0);     flush_line();
    build_rmc(1, 2, 3, 4, 31, 4, 10, 0);     flush_line();
    build_rmc(1, 2, 3, 4, 0, 5, 10, 0);      flush_line();
    build_rmc(1, 2, 3, 4, 10, 0, 10, 0);     flush_line();
    build_rmc(1, 2, 3, 4, 10, 13, 10, 0);    flush_line();
    // short lines
    add_text("$");                           flush_line();
    add_text("$GPRMC");                      flush_line();
    add_text("$GPRMC,");                     flush_line();
    // wrong prefix
    build_rmc(1, 2, 3, 4, 5, 6, 7, 0); line_buf[4] = "G"; line_buf[5] = "A"; flush_line();
    // comma counts: eleven, thirteen, saturated
    build_rmc(1, 2, 3, 4, 5, 6, 7, 0); void'(line_buf.pop_back()); flush_line();
    build_rmc(1, 2, 3, 4, 5, 6, 7, 0); add_text(",");         flush_line();
    build_rmc(1, 2, 3, 4, 5, 6, 7, 0); add_text(",,,,,,,,,"); flush_line();
    // time field lengths: short, long, saturated
    build_rmc(1, 2, 3, 4, 5, 6, 7, 0); line_buf.delete(TIME_START); flush_line();
    build_rmc(1, 2, 3, 4, 5, 6, 7, 0); line_buf.insert(TIME_START, CH_ZERO); flush_line();
    build_rmc(1, 2, 3, 4, 5, 6, 7, 0);
    repeat (12) line_buf.insert(TIME_START, CH_NINE);
    flush_line();
    // date field lengths: short and long
    build_rmc(1, 2, 3, 4, 5, 6, 7, 0); line_buf.delete(comma_pos(9) + 1); flush_line();
    build_rmc(1, 2, 3, 4, 5, 6, 7, 0); line_buf.insert(comma_pos(9) + 1, CH_ZERO); flush_line();
    // non-digits in the hour, the fraction and the date; separator is free
    build_rmc(1, 2, 3, 4, 5, 6, 7, 0); line_buf[TIME_START] = "a"; flush_line();
    build_rmc(1, 2, 3, 4, 5, 6, 7, 0); line_buf[TIME_START + 8] = ":"; flush_line();
    build_rmc(1, 2, 3, 4, 5, 6, 7, 0); line_buf[comma_pos(9) + 3] = "/"; flush_line();
    build_rmc(1, 2, 3, 4, 5, 6, 7, 0); line_buf[TIME_START + 6] = 8'hFF; flush_line();

    while (tx_bytes.size() < TARGET_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        hh = $urandom_range(0, 23);
        mi = $urandom_range(0, 59);
        ss = $urandom_range(0, 59);
        fr = $urandom_range(0, 99);
        mo = $urandom_range(1, 12);
        yy = $urandom_range(0, 99);
        dd = $urandom_range(1, month_days(mo, yy % 4 == 0));
        // now and then push one value anywhere in its two digits
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 5))
            0:       hh = $urandom_range(0, 99);
            1:       mi = $urandom_range(0, 99);
            2:       ss = $urandom_range(0, 99);
            3:       dd = $urandom_range(0, 99);
            4:       mo = $urandom_range(0, 99);
            default: dd = $urandom_range(28, 31);
          endcase
        end
        build_rmc(hh, mi, ss, fr, dd, mo, yy, $urandom_range(0, 3) == 0);
        // damage some sentences
        if (pick >= 70) begin
          pos = $urandom_range(0, line_buf.size() - 1);
          case ($urandom_range(0, 3))
            0:       line_buf[pos] = 8'($urandom_range(0, 255));
            1:       line_buf.insert(pos, 8'($urandom_range(0, 255)));
            2:       line_buf.delete(pos);
            default: while (line_buf.size() > pos + 1) void'(line_buf.pop_back());
          endcase
        end
      end else begin
        line_buf.delete();
        repeat ($urandom_range(1, 12)) line_buf.push_back(8'($urandom_range(0, 255)));
      end
      flush_line();
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // drain: all bytes taken and every result back, then watch for strays
    while (tx_bytes.size() != 0 || in_valid || pending_times.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("** nmea_rmc_time_extractor_core: PASSED **");
    end else begin
      $display("** nmea_rmc_time_extractor_core: FAILED **");
    end
    $finish;
  end

  // Driver: track accepted requests, hold a stalled one, else offer the next
  always @(posedge clk) begin : drive_bytes
    line_byte_t nxt;
    if (!rst_n) begin
      in_valid       <= 1'b0;
      in_line_byte   <= 8'h00;
      in_end_of_line <= 1'b0;
      clear_parser();
    end else begin
      if (in_valid && !in_stall) begin
        bytes_taken <= bytes_taken + 1;
        take_rmc_byte(in_line_byte);
        if (in_end_of_line) begin
          pending_times.push_back(convert_rmc());
          clear_parser();
        end
      end
      if (!in_valid || !in_stall) begin
        if (tx_bytes.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          nxt = tx_bytes.pop_front();
          in_valid       <= 1'b1;
          in_line_byte   <= nxt.data;
          in_end_of_line <= nxt.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each taken result with the oldest line pending
  always @(posedge clk) begin : check_times
    rmc_time_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_times.size() == 0) begin
          $display("%0t: result with no line pending: expected none, %s%0b secs=%0d usecs=%0d",
                   $time, "got valid=", out_time_valid, out_epoch_seconds,
                   out_micro_seconds);
          errors++;
        end else begin
          want = pending_times.pop_front();
          check_field("time_valid", 32'(out_time_valid), 32'(want.ok));
          check_field("epoch_seconds", out_epoch_seconds, want.secs);
          check_field("micro_seconds", 32'(out_micro_seconds), 32'(want.usecs));
        end
      end
      out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Watchdog: end the run when neither channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("** nmea_rmc_time_extractor_core: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ===== nmea_rmc_time_extractor_core.f =====
+incdir+design
design/nrte_pkg.sv
design/nrte_fifo.sv
design/nrte_front.sv
design/nrte_back.sv
design/nmea_rmc_time_extractor_core.sv
test/tb_top.sv
